@@ hw/rtl/cidr_whitelist_match_table_assert.svh @@
// Assertion macros shared by the prefix match table modules.
`ifndef CIDR_WHITELIST_MATCH_TABLE_ASSERT_SVH
`define CIDR_WHITELIST_MATCH_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CWMT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CWMT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CWMT_ASSERT_IMPL(lbl, ante, cons, msg)
`define CWMT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ hw/rtl/cwmt_pkg.sv @@
// Shared types, codes and helper functions of the prefix match table.
package cwmt_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 64;
	localparam int ADDR_W = 32;
	localparam int PLEN_W = 6;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_LOOKUP = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	localparam logic [PLEN_W-1:0] FULL_PREFIX = 6'd32;

	typedef logic [1:0] req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [PLEN_W-1:0] plen;
	} entry_t;

	typedef struct packed {
		logic latch;
		logic insert;
		logic clear;
		logic scan_read;
		logic respond;
	} cwmt_cmd_t;

	typedef struct packed {
		req_t req;
		logic full;
		logic empty;
		logic scan_last;
	} cwmt_stat_t;

	function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
		if (plen == '0) begin
			return '0;
		end
		return {ADDR_W{1'b1}} << (FULL_PREFIX - plen);
	endfunction

	function automatic logic [PLEN_W-1:0] sat_prefix(input logic [PLEN_W-1:0] plen);
		return (plen > FULL_PREFIX) ? FULL_PREFIX : plen;
	endfunction

endpackage

@@ hw/rtl/cwmt_ctrl.sv @@
// Controller state machine that sequences insert, lookup and clear items.
`include "cidr_whitelist_match_table_assert.svh"
module cwmt_ctrl import cwmt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  cwmt_stat_t stat,
	output cwmt_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE     = 2'd0;
	localparam logic [1:0] ST_DISPATCH = 2'd1;
	localparam logic [1:0] ST_SCAN     = 2'd2;
	localparam logic [1:0] ST_DRAIN    = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (stat.req)
					REQ_INSERT: begin
						cmd.insert = 1'b1;
						cmd.respond = 1'b1;
						state_d = ST_IDLE;
					end
					REQ_LOOKUP: begin
						if (stat.empty) begin
							cmd.respond = 1'b1;
							state_d = ST_IDLE;
						end else begin
							state_d = ST_SCAN;
						end
					end
					REQ_CLEAR: begin
						cmd.clear = 1'b1;
						cmd.respond = 1'b1;
						state_d = ST_IDLE;
					end
					default: begin
						cmd.respond = 1'b1;
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_SCAN: begin
				cmd.scan_read = 1'b1;
				if (stat.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				cmd.respond = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`CWMT_ASSERT_NEXT(a_accept_dispatch, start && !busy, state_q == ST_DISPATCH, "accepted item did not dispatch")
	`CWMT_ASSERT_NEXT(a_scan_holds, (state_q == ST_SCAN) && !stat.scan_last, state_q == ST_SCAN, "scan left early")
	`CWMT_ASSERT_NEXT(a_drain_idle, state_q == ST_DRAIN, state_q == ST_IDLE, "drain did not return to idle")

endmodule

@@ hw/rtl/cwmt_datapath.sv @@
// Datapath with the entry memory, entry count, scan pointer and match logic.
`include "cidr_whitelist_match_table_assert.svh"
module cwmt_datapath import cwmt_pkg::*; #(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          req_type,
	input  logic [ADDR_W-1:0]   address,
	input  logic [PLEN_W-1:0]   prefix_len,
	input  cwmt_cmd_t           cmd,
	output cwmt_stat_t          stat,
	output logic                done,
	output logic                hit,
	output logic                status
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	entry_t mem [TABLE_DEPTH];

	req_t              req_q;
	logic [ADDR_W-1:0] key_q;
	logic [PLEN_W-1:0] plen_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  ptr_next;
	entry_t            rdata_q;
	logic              rd_valid_q;
	logic              hit_q;
	logic              cur_match;
	logic              full;
	logic              done_q;
	logic              hit_o_q;
	logic              status_o_q;
	logic [ADDR_W-1:0] mask;

	assign full = (count_q == CNT_W'(TABLE_DEPTH));
	assign ptr_next = ptr_q + CNT_W'(1);
	assign mask = prefix_mask(rdata_q.plen);
	assign cur_match = rd_valid_q && (((rdata_q.addr ^ key_q) & mask) == '0);

	assign stat.req = req_q;
	assign stat.full = full;
	assign stat.empty = (count_q == '0);
	assign stat.scan_last = (ptr_next == count_q);

	assign done = done_q;
	assign hit = hit_o_q;
	assign status = status_o_q;

	always_ff @(posedge clk) begin
		if (cmd.insert && !full) begin
			mem[count_q[IDX_W-1:0]] <= '{addr: key_q, plen: plen_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_read) begin
			rdata_q <= mem[ptr_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req_type;
			key_q <= address;
			plen_q <= sat_prefix(prefix_len);
		end
		if (cmd.respond) begin
			hit_o_q <= (req_q == REQ_LOOKUP) && (hit_q || cur_match);
			status_o_q <= (req_q == REQ_INSERT) && full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q <= '0;
			rd_valid_q <= 1'b0;
			hit_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.respond;
			rd_valid_q <= cmd.scan_read;
			if (cmd.latch) begin
				ptr_q <= '0;
				hit_q <= 1'b0;
			end else begin
				if (cmd.scan_read) begin
					ptr_q <= ptr_next;
				end
				if (cur_match) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.insert && !full) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	`CWMT_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(TABLE_DEPTH), "entry count above depth")
	`CWMT_ASSERT_IMPL(a_read_in_range, cmd.scan_read, ptr_q < count_q, "scan read past stored entries")
	`CWMT_ASSERT_NEXT(a_done_single, done_q, !done_q, "result strobe held two cycles")

endmodule

@@ hw/rtl/cidr_whitelist_match_table.sv @@
// Top level of the IPv4 prefix match table: controller plus datapath.
//
// Usage: drive req_type, address and prefix_len with start high; the item is
// taken at the clock edge where start is high and busy is low. req_type 0
// inserts an entry (prefix lengths above 32 act as 32), 1 looks up an
// address against every stored entry, 2 clears the table.
// Every item gives exactly one result: done is high for one cycle with hit
// and status valid in that cycle. The receiver cannot stall, so the result
// is simply lost if not sampled then.
// An insert, clear, unused code or lookup on an empty table sets done from
// the dispatch state through the done register, and a new item can be taken
// while done is shown. A lookup runs through the scan and drain states; the
// scan reads the single read port of the entry memory once a cycle.
// Reset empties the table and returns the controller to idle; no clearing
// pass is needed since only entries below the fill count are ever read.
module cidr_whitelist_match_table import cwmt_pkg::*; #(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        req_type,
	input  logic [ADDR_W-1:0] address,
	input  logic [PLEN_W-1:0] prefix_len,
	output logic              done,
	output logic              hit,
	output logic              status
);

	cwmt_cmd_t  cmd;
	cwmt_stat_t stat;

	cwmt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	cwmt_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_type   (req_type),
		.address    (address),
		.prefix_len (prefix_len),
		.cmd        (cmd),
		.stat       (stat),
		.done       (done),
		.hit        (hit),
		.status     (status)
	);

endmodule
